@@ design/id_registry_with_timeout_defines.svh @@
// Assertion macros shared by the checker files of the identifier registry.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ID_REGISTRY_WITH_TIMEOUT_DEFINES_SVH
`define ID_REGISTRY_WITH_TIMEOUT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id registry check failed");

// Next-cycle implication, checked outside reset.
`define IDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id registry check failed");

`endif

@@ design/idr_pkg.sv @@
`timescale 1ns / 1ps

package idr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] TIMEOUT_RESET = 32'd30;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_PURGE  = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seen;
    } entry_t;

endpackage

@@ design/id_registry_with_timeout.sv @@
`timescale 1ns / 1ps

// Registry of 32-bit identifiers, each kept with the time at which it was inserted.
// Input channel: in_valid/in_stall carry one command beat (operation, ue_id, now).
// Output channel: out_valid/out_stall carry result beats (status, found_id,
// found_seen, last); last marks the final beat caused by a command.
// The user writes the timeout through cfg_wr_en/cfg_wr_data while the block is idle;
// the block itself does not enforce this. Entries live in a 16-entry memory used as a
// ring, newest first from head_reg. Insert moves the head back by one and writes there:
// the result is registered from ST_INSERT once the output register is free.
// Delete, search and purge walk the N stored entries through the memory's one
// read port, one entry per cycle unless a purge waits for a free output slot,
// compacting survivors through the write port. Their final beat is registered
// from ST_FINISH once the output register is free.
// A purge that expires several entries holds back each result until the next
// expiry or the end of the walk, so that last can be set on the true final beat.
// When out_stall is high the output register holds; a purge walk then waits on
// its next expiry, and no command is taken until the walk ends.
// Reset empties the table, restores the timeout to 30 and clears both channels;
// the memory contents are not cleared, as empty slots are never read.
module id_registry_with_timeout (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] ue_id,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] found_id,
    output logic [31:0] found_seen,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam int IDX_W = idr_pkg::IDX_W;
    localparam int CNT_W = idr_pkg::CNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(idr_pkg::TABLE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(idr_pkg::TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(idr_pkg::TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Maps a position in newest-first order onto a physical slot of the ring.
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Entry memory with a registered read port.
    idr_pkg::entry_t mem [idr_pkg::TABLE_DEPTH];
    idr_pkg::entry_t rd_data_reg;
    logic            mem_we;
    logic            mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    idr_pkg::entry_t mem_wdata;

    state_t             state_reg,      state_next;
    idr_pkg::op_t       op_reg,         op_next;
    logic [31:0]        id_reg,         id_next;
    logic [31:0]        now_reg,        now_next;
    logic [31:0]        timeout_reg,    timeout_next;
    logic [IDX_W-1:0]   head_reg,       head_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [CNT_W-1:0]   rd_idx_reg,     rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg,     wr_idx_next;
    logic               rd_pend_reg,    rd_pend_next;
    logic               hit_reg,        hit_next;
    logic               pend_valid_reg, pend_valid_next;
    idr_pkg::entry_t    pend_entry_reg, pend_entry_next;
    logic               out_valid_reg,  out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [31:0]        out_id_reg,     out_id_next;
    logic [31:0]        out_seen_reg,   out_seen_next;
    logic               out_last_reg,   out_last_next;

    logic             slot_free;
    logic [IDX_W-1:0] head_dec;
    logic [31:0]      age;
    logic             expired;
    logic             match;
    logic             hit;
    logic             remove;
    logic             go;
    logic             issue;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_id   = out_id_reg;
    assign found_seen = out_seen_reg;
    assign last       = out_last_reg;

    // The output register can take a new beat when it is empty or being drained.
    assign slot_free = !out_valid_reg || !out_stall;
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - IDX_W'(1);

    // Evaluation of the entry whose read data arrived this cycle.
    assign age     = now_reg - rd_data_reg.seen;
    assign expired = (age > timeout_reg);
    assign match   = (rd_data_reg.id == id_reg);
    assign hit     = (op_reg == idr_pkg::OP_PURGE) ? expired : (match && !hit_reg);
    assign remove  = hit && (op_reg != idr_pkg::OP_SEARCH);

    // A second expiry pushes the held result out, which needs a free output slot.
    assign go    = !rd_pend_reg || !(hit && pend_valid_reg) || slot_free;
    assign issue = (rd_idx_reg < count_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        rd_pend_next    = rd_pend_reg;
        hit_next        = hit_reg;
        pend_valid_next = pend_valid_reg;
        pend_entry_next = pend_entry_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_seen_next   = out_seen_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = phys_addr(head_reg, wr_idx_reg[IDX_W-1:0]);
        mem_wdata       = rd_data_reg;
        mem_raddr       = phys_addr(head_reg, rd_idx_reg[IDX_W-1:0]);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = idr_pkg::op_t'(operation);
                    id_next         = ue_id;
                    now_next        = now;
                    rd_idx_next     = '0;
                    wr_idx_next     = '0;
                    rd_pend_next    = 1'b0;
                    hit_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    if (idr_pkg::op_t'(operation) == idr_pkg::OP_INSERT)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_INSERT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_seen_next  = '0;
                    out_last_next  = 1'b1;
                    if (count_reg == FULL_COUNT)
                    begin
                        out_status_next = idr_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        out_status_next = idr_pkg::STATUS_OK;
                        mem_we          = 1'b1;
                        mem_waddr       = head_dec;
                        mem_wdata.id    = id_reg;
                        mem_wdata.seen  = now_reg;
                        head_next       = head_dec;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (go)
                begin
                    if (rd_pend_reg)
                    begin
                        // Survivors slide down to the write position; search
                        // leaves the table as it is.
                        if (!remove)
                        begin
                            mem_we      = (op_reg != idr_pkg::OP_SEARCH);
                            wr_idx_next = wr_idx_reg + CNT_W'(1);
                        end
                        if (hit)
                        begin
                            hit_next        = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_entry_next = rd_data_reg;
                            if (pend_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = idr_pkg::STATUS_OK;
                                out_id_next     = pend_entry_reg.id;
                                out_seen_next   = pend_entry_reg.seen;
                                out_last_next   = 1'b0;
                            end
                        end
                    end
                    if (issue)
                    begin
                        mem_re       = 1'b1;
                        rd_idx_next  = rd_idx_reg + CNT_W'(1);
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        count_next   = wr_idx_next;
                        state_next   = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status_next = idr_pkg::STATUS_OK;
                        out_id_next     = pend_entry_reg.id;
                        out_seen_next   = pend_entry_reg.seen;
                    end
                    else
                    begin
                        out_status_next = idr_pkg::STATUS_NOT_FOUND;
                        out_id_next     = '0;
                        out_seen_next   = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= idr_pkg::OP_INSERT;
            id_reg         <= '0;
            now_reg        <= '0;
            timeout_reg    <= idr_pkg::TIMEOUT_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_entry_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= idr_pkg::STATUS_OK;
            out_id_reg     <= '0;
            out_seen_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            now_reg        <= now_next;
            timeout_reg    <= timeout_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            rd_pend_reg    <= rd_pend_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            pend_entry_reg <= pend_entry_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_seen_reg   <= out_seen_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Read data holds while no read is issued, so a stalled walk keeps its entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

@@ design/idr_checker.sv @@
`timescale 1ns / 1ps
`include "id_registry_with_timeout_defines.svh"

module idr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] found_id,
    input logic [31:0] found_seen,
    input logic        last
);

    // A failure beat is always a lone final beat with empty payload.
    `IDR_ASSERT_IMP(a_fail_beat_empty, out_valid && (status != idr_pkg::STATUS_OK), last && (found_id == 32'd0) && (found_seen == 32'd0))

    // Commands are handled one at a time: after a command beat the block is busy.
    `IDR_ASSERT_NXT(a_busy_after_cmd, in_valid && !in_stall, in_stall)

    // While a multi-beat purge result is still open, no new command is taken.
    `IDR_ASSERT_IMP(a_open_burst_busy, out_valid && !last, in_stall)

    // A stalled result beat holds.
    `IDR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(found_id) && $stable(found_seen) && $stable(last))

endmodule

bind id_registry_with_timeout idr_checker u_idr_checker (.*);
